>>> sv/flm_pkg.sv
// Shared types, constants and helper functions for the fixed-string line matcher.
// No dependencies; every other file refers to this package by scoped names.
package flm_pkg;

    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam int PATTERN_BITS = 128;   // 16 characters from two 64-bit registers
    localparam int LEN_W        = 5;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int OUT_DATA_W   = 72;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PATTERN_LO   = 3'd0,
        CFG_PATTERN_HI   = 3'd1,
        CFG_PATTERN_LEN  = 3'd2,
        CFG_IGNORE_CASE  = 3'd3,
        CFG_WHOLE_LINE   = 3'd4,
        CFG_INVERT       = 3'd5
    } cfg_index_t;

    typedef enum logic {
        KIND_LINE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic [LEN_W-1:0]        length;
        logic                    ignore_case;
        logic                    whole_line;
        logic                    invert;
    } cfg_t;

    typedef struct packed {
        result_kind_t kind;
        logic         selected;
        logic [31:0]  line_number;
        logic [31:0]  count;
        logic         binary;
        logic         last;
    } out_item_t;

    typedef struct packed {
        logic      valid0;
        logic      valid1;
        out_item_t item0;
        out_item_t item1;
    } push_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && (c inside {[UPPER_A:UPPER_Z]}))
            return c + CASE_OFFSET;
        return c;
    endfunction

    // Characters 16 and up read as zero.
    function automatic logic [7:0] pattern_char(input logic [PATTERN_BITS-1:0] pat,
                                                input logic [6:0] idx);
        if (idx < 7'd16)
            return pat[{idx[3:0], 3'b000} +: 8];
        return NUL_CHAR;
    endfunction

endpackage

>>> sv/fixed_string_line_matcher.sv
// An item accepted on s_ is held in the input register; it enters the line engine only
// while the result queue has two free slots; the engine writes its results into the queue.
// Throughput: one input item per cycle while the queue has two free slots; results leave one
// per cycle through a four-entry queue while m_tready is high, and an end of file closing a
// pending line pushes two results at once.
// Reset (aresetn low, synchronous) clears the registers, line state and queue.
// Depends on flm_pkg, flm_line_engine, flm_result_queue.
module fixed_string_line_matcher #(
    parameter int MAX_PATTERN_CHARS = 16,
    parameter int COUNT_BITS        = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tuser,   // [0] end_of_file
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] line_selected, [32:1] line_number, [64:33] selected_count,
    // [65] binary_seen, [71:66] zero
    output logic [flm_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tuser,   // [0] result_kind
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [flm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [flm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    flm_pkg::cfg_t      cfg_reg;
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_eof_reg;
    logic               take, room_two, pop;
    flm_pkg::push_t     push;
    flm_pkg::out_item_t head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (flm_pkg::cfg_index_t'(cfg_addr))
                flm_pkg::CFG_PATTERN_LO:  cfg_reg.pattern[63:0]   <= cfg_wdata;
                flm_pkg::CFG_PATTERN_HI:  cfg_reg.pattern[127:64] <= cfg_wdata;
                flm_pkg::CFG_PATTERN_LEN: cfg_reg.length          <= cfg_wdata[4:0];
                flm_pkg::CFG_IGNORE_CASE: cfg_reg.ignore_case     <= cfg_wdata[0];
                flm_pkg::CFG_WHOLE_LINE:  cfg_reg.whole_line      <= cfg_wdata[0];
                flm_pkg::CFG_INVERT:      cfg_reg.invert          <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register; drains into the engine whenever the queue has two free slots
    assign take     = in_valid_reg && room_two;
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tuser;
        end
    end

    flm_line_engine #(
        .MAX_PATTERN_CHARS(MAX_PATTERN_CHARS),
        .COUNT_BITS(COUNT_BITS)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn), .take(take),
        .in_byte(in_byte_reg), .in_eof(in_eof_reg), .cfg(cfg_reg), .push(push)
    );

    assign pop = m_tvalid && m_tready;

    flm_result_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .pop(pop),
        .room_two(room_two), .not_empty(m_tvalid), .head(head)
    );

    assign m_tdata = {6'd0, head.binary, head.count, head.line_number, head.selected};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

>>> sv/flm_tail_match.sv
// Parallel compare of the newest bytes of a line against the configured pattern.
// Depends on flm_pkg (cfg_t, fold, pattern_char).
module flm_tail_match #(
    parameter int MAX_PATTERN_CHARS = 16,
    parameter int CIL_W             = 5
) (
    input  logic [MAX_PATTERN_CHARS-1:0][7:0] window,   // newest byte at index 0
    input  logic [CIL_W-1:0]                  chars,
    input  flm_pkg::cfg_t                     cfg,
    output logic                              match
);

    logic [MAX_PATTERN_CHARS-1:0] ok;
    logic [7:0]                   len8;

    assign len8 = 8'(cfg.length);

    always_comb begin
        logic [7:0] p;
        for (int j = 0; j < MAX_PATTERN_CHARS; j++) begin
            // window byte j lines up with pattern character len-1-j
            p = flm_pkg::pattern_char(cfg.pattern, 7'(cfg.length) - 7'd1 - 7'(j));
            ok[j] = (8'(j) >= len8) ||
                    ((p != flm_pkg::NUL_CHAR) &&
                     (flm_pkg::fold(p, cfg.ignore_case) ==
                      flm_pkg::fold(window[j], cfg.ignore_case)));
        end
    end

    assign match = (len8 != 8'd0) && (len8 <= 8'(MAX_PATTERN_CHARS)) &&
                   (8'(chars) >= len8) && (&ok);

endmodule

>>> sv/flm_line_engine.sv
// Per-file line state and the single-pass update for one registered item.
// Depends on flm_pkg and flm_tail_match.
module flm_line_engine #(
    parameter int MAX_PATTERN_CHARS = 16,
    parameter int COUNT_BITS        = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          take,
    input  logic [7:0]    in_byte,
    input  logic          in_eof,
    input  flm_pkg::cfg_t cfg,
    output flm_pkg::push_t push
);

    localparam int CIL_W = $clog2(MAX_PATTERN_CHARS + 2);
    localparam logic [CIL_W-1:0]      CIL_SAT   = CIL_W'(MAX_PATTERN_CHARS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [MAX_PATTERN_CHARS-1:0][7:0] win_reg, win_next, win_push;
    logic [CIL_W-1:0]                  cil_reg, cil_next, cil_inc;
    logic                              found_reg, found_next;
    logic [COUNT_BITS-1:0]             line_reg, line_next, line_inc;
    logic [COUNT_BITS-1:0]             cnt_reg, cnt_next, cnt_fin, sum_cnt;
    logic                              binary_reg, binary_next;
    logic                              stopped_reg, stopped_next;

    logic        tail_new, tail_cur, matched, sel, do_fin;
    logic [63:0] line_ext, cnt_fin_ext, sum_ext;
    flm_pkg::out_item_t line_item, sum_item;

    always_comb begin
        win_push[0] = in_byte;
        for (int j = 1; j < MAX_PATTERN_CHARS; j++)
            win_push[j] = win_reg[j-1];
    end

    assign cil_inc = (cil_reg < CIL_SAT) ? cil_reg + CIL_W'(1) : cil_reg;

    flm_tail_match #(.MAX_PATTERN_CHARS(MAX_PATTERN_CHARS), .CIL_W(CIL_W)) u_match_new (
        .window(win_push), .chars(cil_inc), .cfg(cfg), .match(tail_new)
    );

    flm_tail_match #(.MAX_PATTERN_CHARS(MAX_PATTERN_CHARS), .CIL_W(CIL_W)) u_match_cur (
        .window(win_reg), .chars(cil_reg), .cfg(cfg), .match(tail_cur)
    );

    always_comb begin
        if (cil_reg == '0)
            matched = 1'b0;
        else if (cfg.whole_line)
            matched = (8'(cil_reg) == 8'(cfg.length)) && tail_cur;
        else
            matched = found_reg;
        sel      = matched ^ cfg.invert;
        cnt_fin  = (sel && cnt_reg != COUNT_MAX) ? cnt_reg + COUNT_BITS'(1) : cnt_reg;
        line_inc = (line_reg != COUNT_MAX) ? line_reg + COUNT_BITS'(1) : line_reg;
        do_fin   = !stopped_reg && (cil_reg != '0);
        sum_cnt  = do_fin ? cnt_fin : cnt_reg;
    end

    assign line_ext    = 64'(line_reg);
    assign cnt_fin_ext = 64'(cnt_fin);
    assign sum_ext     = 64'(sum_cnt);

    always_comb begin
        line_item.kind        = flm_pkg::KIND_LINE;
        line_item.selected    = sel;
        line_item.line_number = line_ext[31:0];
        line_item.count       = cnt_fin_ext[31:0];
        line_item.binary      = binary_reg;
        line_item.last        = 1'b1;

        sum_item.kind         = flm_pkg::KIND_SUMMARY;
        sum_item.selected     = (sum_cnt != '0);
        sum_item.line_number  = '0;
        sum_item.count        = sum_ext[31:0];
        sum_item.binary       = binary_reg;
        sum_item.last         = 1'b1;
    end

    always_comb begin
        win_next     = win_reg;
        cil_next     = cil_reg;
        found_next   = found_reg;
        line_next    = line_reg;
        cnt_next     = cnt_reg;
        binary_next  = binary_reg;
        stopped_next = stopped_reg;
        push         = '0;

        if (take) begin
            if (in_eof) begin
                // pending line (if any) first, then the summary; per-file state clears
                if (do_fin) begin
                    push.valid0     = 1'b1;
                    push.item0      = line_item;
                    push.item0.last = 1'b0;
                    push.valid1     = 1'b1;
                    push.item1      = sum_item;
                end else begin
                    push.valid0 = 1'b1;
                    push.item0  = sum_item;
                end
                win_next     = '0;
                cil_next     = '0;
                found_next   = 1'b0;
                line_next    = COUNT_BITS'(1);
                cnt_next     = '0;
                binary_next  = 1'b0;
                stopped_next = 1'b0;
            end else if (!stopped_reg) begin
                if (in_byte == flm_pkg::NUL_CHAR || in_byte == flm_pkg::NEWLINE_CHAR) begin
                    // a leading NUL only marks the file binary
                    if (in_byte == flm_pkg::NUL_CHAR)
                        binary_next = 1'b1;
                    if (in_byte == flm_pkg::NEWLINE_CHAR || cil_reg != '0) begin
                        push.valid0        = 1'b1;
                        push.item0         = line_item;
                        push.item0.binary  = binary_next;
                        line_next          = line_inc;
                        cnt_next           = cnt_fin;
                        win_next           = '0;
                        cil_next           = '0;
                        found_next         = 1'b0;
                        stopped_next       = (cnt_fin != '0) && binary_next;
                    end
                end else begin
                    win_next = win_push;
                    cil_next = cil_inc;
                    if (cfg.length == '0 || tail_new)
                        found_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            cil_reg     <= '0;
            found_reg   <= 1'b0;
            line_reg    <= COUNT_BITS'(1);
            cnt_reg     <= '0;
            binary_reg  <= 1'b0;
            stopped_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            cil_reg     <= cil_next;
            found_reg   <= found_next;
            line_reg    <= line_next;
            cnt_reg     <= cnt_next;
            binary_reg  <= binary_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

>>> sv/flm_result_queue.sv
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on flm_pkg (out_item_t, push_t, queue sizes).
module flm_result_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  flm_pkg::push_t     push,
    input  logic               pop,
    output logic               room_two,
    output logic               not_empty,
    output flm_pkg::out_item_t head
);

    flm_pkg::out_item_t               entries [flm_pkg::QUEUE_DEPTH];
    logic [flm_pkg::QPTR_W-1:0]       wr_reg, wr_next, rd_reg, rd_next;
    logic [flm_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic [flm_pkg::QPTR_W-1:0]       wr_plus1;
    logic [1:0]                       n_push;

    assign wr_plus1  = wr_reg + flm_pkg::QPTR_W'(1);
    assign n_push    = 2'(push.valid0) + 2'(push.valid1);
    assign room_two  = cnt_reg <= flm_pkg::QCNT_W'(flm_pkg::QUEUE_DEPTH - 2);
    assign not_empty = cnt_reg != '0;
    assign head      = entries[rd_reg];

    always_comb begin
        wr_next  = wr_reg + flm_pkg::QPTR_W'(n_push);
        rd_next  = pop ? rd_reg + flm_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + flm_pkg::QCNT_W'(n_push) - flm_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.valid0)
            entries[wr_reg] <= push.item0;
        if (push.valid1)
            entries[wr_plus1] <= push.item1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> tb/flm_checker.sv
// Scoreboard for fixed_string_line_matcher: follows register writes and accepted items,
// works out the line and end-of-file results and checks them against the m_ channel.
// Depends on flm_pkg for register indexes, result kinds and the result record.
`timescale 1ns / 1ps

module flm_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [flm_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    input  logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [flm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [flm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             lines_done,
    output int                             files_done,
    output int                             lines_picked
);

    localparam int WINDOW = 16;
    localparam logic [31:0] COUNT_TOP = '1;

    // register copies
    logic [127:0] pat;
    logic [4:0]   pat_len;
    logic         ic;
    logic         whole;
    logic         inv;

    // per-file state
    logic [7:0]   recent [WINDOW];   // newest byte at index 0
    logic [4:0]   line_len;          // saturates at WINDOW + 1
    logic         found;
    logic         binary;
    logic         stopped;
    logic [31:0]  line_no;
    logic [31:0]  sel_count;

    flm_pkg::out_item_t results_due [$];

    function automatic logic [7:0] lower(input logic [7:0] c);
        if (ic && c >= flm_pkg::UPPER_A && c <= flm_pkg::UPPER_Z)
            return c + flm_pkg::CASE_OFFSET;
        return c;
    endfunction

    // newest len bytes of the line against the pattern
    function automatic logic tail_equals(input logic [4:0] len);
        logic [7:0] p;
        if (len == 0 || len > WINDOW || line_len < len)
            return 1'b0;
        for (int i = 0; i < len; i++) begin
            p = pat[8*i +: 8];
            if (p == flm_pkg::NUL_CHAR || lower(p) != lower(recent[len-1-i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_line();
        for (int i = 0; i < WINDOW; i++)
            recent[i] = '0;
        line_len = '0;
        found = 1'b0;
    endfunction

    function automatic void clear_file();
        clear_line();
        line_no = 32'd1;
        sel_count = '0;
        binary = 1'b0;
        stopped = 1'b0;
    endfunction

    function automatic flm_pkg::out_item_t close_line();
        flm_pkg::out_item_t r;
        logic hit;
        if (line_len == 0)
            hit = 1'b0;
        else if (whole)
            hit = (line_len == pat_len) && tail_equals(pat_len);
        else
            hit = found;
        hit = hit ^ inv;
        if (hit && sel_count != COUNT_TOP)
            sel_count++;
        r.kind = flm_pkg::KIND_LINE;
        r.selected = hit;
        r.line_number = line_no;
        r.count = sel_count;
        r.binary = binary;
        r.last = 1'b0;
        if (line_no != COUNT_TOP)
            line_no++;
        clear_line();
        // a selected line in a binary file ends the search
        if (sel_count != 0 && binary)
            stopped = 1'b1;
        return r;
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        for (int i = WINDOW - 1; i > 0; i--)
            recent[i] = recent[i-1];
        recent[0] = c;
        if (line_len <= WINDOW)
            line_len++;
        if (pat_len == 0 || tail_equals(pat_len))
            found = 1'b1;
    endfunction

    function automatic void predict(input logic [7:0] b, input logic eof);
        flm_pkg::out_item_t r;
        if (eof) begin
            if (!stopped && line_len != 0)
                results_due.push_back(close_line());
            r.kind = flm_pkg::KIND_SUMMARY;
            r.selected = (sel_count != 0);
            r.line_number = '0;
            r.count = sel_count;
            r.binary = binary;
            r.last = 1'b1;
            results_due.push_back(r);
            clear_file();
        end else if (!stopped) begin
            if (b == flm_pkg::NUL_CHAR) begin
                binary = 1'b1;
                // NUL on an empty line is skipped
                if (line_len != 0) begin
                    r = close_line();
                    r.last = 1'b1;
                    results_due.push_back(r);
                end
            end else if (b == flm_pkg::NEWLINE_CHAR) begin
                r = close_line();
                r.last = 1'b1;
                results_due.push_back(r);
            end else begin
                add_byte(b);
            end
        end
    endfunction

    always @(posedge aclk) begin
        flm_pkg::out_item_t want;
        flm_pkg::out_item_t got;
        if (!aresetn) begin
            pat = '0;
            pat_len = '0;
            ic = 1'b0;
            whole = 1'b0;
            inv = 1'b0;
            clear_file();
            results_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    flm_pkg::CFG_PATTERN_LO:  pat[63:0] = cfg_wdata;
                    flm_pkg::CFG_PATTERN_HI:  pat[127:64] = cfg_wdata;
                    flm_pkg::CFG_PATTERN_LEN: pat_len = cfg_wdata[4:0];
                    flm_pkg::CFG_IGNORE_CASE: ic = cfg_wdata[0];
                    flm_pkg::CFG_WHOLE_LINE:  whole = cfg_wdata[0];
                    flm_pkg::CFG_INVERT:      inv = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got.kind = flm_pkg::result_kind_t'(m_tuser);
                got.selected = m_tdata[0];
                got.line_number = m_tdata[32:1];
                got.count = m_tdata[64:33];
                got.binary = m_tdata[65];
                got.last = m_tlast;
                if (results_due.size() == 0) begin
                    if (fail_count < 20)
                        $display("%0t: unexpected result, got kind %0d sel %0d",
                                 $time, got.kind, got.selected,
                                 " line %0d count %0d", got.line_number, got.count);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got !== want || m_tdata[71:66] !== '0) begin
                        if (fail_count < 20)
                            $display("%0t: mismatch, expected kind %0d sel %0d line %0d",
                                     $time, want.kind, want.selected, want.line_number,
                                     " count %0d bin %0d last %0d,", want.count,
                                     want.binary, want.last,
                                     " got kind %0d sel %0d line %0d", got.kind,
                                     got.selected, got.line_number,
                                     " count %0d bin %0d last %0d pad %0h", got.count,
                                     got.binary, got.last, m_tdata[71:66]);
                        fail_count++;
                    end
                    if (want.kind == flm_pkg::KIND_LINE) begin
                        lines_done++;
                        if (want.selected)
                            lines_picked++;
                    end else begin
                        files_done++;
                    end
                end
            end
        end
        pending = results_due.size();
    end

endmodule

>>> tb/tb_top.sv
// Top of the fixed_string_line_matcher testbench: clock, reset, register writes and the
// byte stream; flm_checker does the checking. Depends on flm_pkg, flm_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 195;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [flm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           cfg_wr_en = 1'b0;
    logic [flm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [flm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int lines_done;
    int files_done;
    int lines_picked;

    int send_idle = 0;        // percent of cycles
    int recv_idle = 0;
    int hold_asked = 0;
    int hold_given = 0;
    int items_sent = 0;
    int settings_loaded = 0;
    int cycles = 0;

    logic [127:0] cur_pat;
    logic [4:0]   cur_len;

    fixed_string_line_matcher uut (.*);

    flm_checker u_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_given) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_given++;
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eof;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(s[k], 1'b0);
    endtask

    // wait for all results, then for bytes still in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(input flm_pkg::cfg_index_t idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic load_settings(input logic [127:0] p, input logic [4:0] len,
                                 input bit nocase, input bit whole, input bit inv);
        write_reg(flm_pkg::CFG_PATTERN_LO, p[63:0]);
        write_reg(flm_pkg::CFG_PATTERN_HI, p[127:64]);
        write_reg(flm_pkg::CFG_PATTERN_LEN, 64'(len));
        write_reg(flm_pkg::CFG_IGNORE_CASE, 64'(nocase));
        write_reg(flm_pkg::CFG_WHOLE_LINE, 64'(whole));
        write_reg(flm_pkg::CFG_INVERT, 64'(inv));
        cfg_wr_en <= 1'b0;
        cur_pat = p;
        cur_len = len;
        settings_loaded++;
    endtask

    function automatic logic [7:0] maybe_flip(input logic [7:0] c);
        logic [7:0] low;
        low = c | flm_pkg::CASE_OFFSET;
        if (low >= "a" && low <= "z" && $urandom_range(3) == 0)
            return c ^ flm_pkg::CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [127:0] make_pattern(input int len);
        logic [127:0] p;
        p = {$urandom, $urandom, $urandom, $urandom};   // bytes past the length stay random
        for (int k = 0; k < len && k < 16; k++)
            p[8*k +: 8] = maybe_flip(8'("a" + $urandom_range(2)));
        return p;
    endfunction

    // line byte: mostly pattern letters or a small alphabet, some arbitrary bytes
    function automatic logic [7:0] line_char();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 55 && cur_len != 0)
            c = cur_pat[8*$urandom_range((cur_len > 16 ? 16 : cur_len) - 1) +: 8];
        else if (pick < 85)
            c = 8'("a" + $urandom_range(3));
        else
            c = 8'($urandom_range(255));
        c = maybe_flip(c);
        if (c == flm_pkg::NUL_CHAR || c == flm_pkg::NEWLINE_CHAR)
            c = "q";
        return c;
    endfunction

    task automatic send_pattern();
        logic [7:0] c;
        for (int k = 0; k < cur_len && k < 16; k++) begin
            c = maybe_flip(cur_pat[8*k +: 8]);
            if (c != flm_pkg::NUL_CHAR)
                send_item(c, 1'b0);
        end
    endtask

    task automatic send_line(input bit may_skip_end);
        int style;
        style = $urandom_range(99);
        if (style >= 10 && style < 30) begin
            send_pattern();
        end else if (style >= 30 && style < 60) begin
            repeat ($urandom_range(4)) send_item(line_char(), 1'b0);
            send_pattern();
            repeat ($urandom_range(4)) send_item(line_char(), 1'b0);
        end else if (style >= 60) begin
            repeat ($urandom_range(1, 20)) send_item(line_char(), 1'b0);
        end
        // last line may be left open for the end of file to close
        if (!(may_skip_end && $urandom_range(2) == 0))
            send_item($urandom_range(15) == 0 ? flm_pkg::NUL_CHAR : flm_pkg::NEWLINE_CHAR,
                      1'b0);
    endtask

    task automatic send_file();
        int n;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 2)) send_item(flm_pkg::NUL_CHAR, 1'b0);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_line(i == n - 1);
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic run_phase(input logic [127:0] p, input logic [4:0] len, input bit nocase,
                             input bit whole, input bit inv, input int sidle, input int ridle);
        int start;
        drain();
        load_settings(p, len, nocase, whole, inv);
        send_idle = sidle;
        recv_idle = ridle;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            send_file();
    endtask

    initial begin
        logic [127:0] zero_pat;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: pattern "aB" with case folding
        load_settings(128'h4261, 5'd2, 1'b1, 1'b0, 1'b0);
        send_text("\nxAb\n");                 // empty line, then a folded match
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_text("\naB");
        send_item(8'hA5, 1'b1);               // end of file closes the open line
        send_item(flm_pkg::NUL_CHAR, 1'b0);   // leading NUL: skipped, file turns binary
        send_text("aB");
        send_item(flm_pkg::NUL_CHAR, 1'b0);   // selected line in a binary file stops it
        send_text("aB\nz");
        send_item(8'h00, 1'b1);               // open line dropped
        send_item(8'h5A, 1'b1);               // empty file

        // receiver holds off at the start of the next phase while bytes keep coming
        drain();
        hold_asked++;

        run_phase(make_pattern(3), 5'd3, 1'b0, 1'b0, 1'b0, 0, 0);
        run_phase(make_pattern(2), 5'd2, 1'b1, 1'b0, 1'b1, 47, 0);
        run_phase(make_pattern(0), 5'd0, 1'b0, 1'b0, 1'b0, 0, 47);   // empty pattern
        run_phase(make_pattern(0), 5'd0, 1'b1, 1'b1, 1'b1, 6, 6);
        run_phase(make_pattern(16), 5'd16, 1'b1, 1'b0, 1'b0, 0, 0);
        run_phase(make_pattern(16), 5'd16, 1'b0, 1'b1, 1'b0, 47, 0);
        run_phase(make_pattern(16), 5'd31, 1'b0, 1'b0, 1'b1, 0, 47); // length past the max
        zero_pat = make_pattern(3);
        zero_pat[15:8] = flm_pkg::NUL_CHAR;                           // NUL inside the pattern
        run_phase(zero_pat, 5'd3, 1'b1, 1'b0, 1'b0, 6, 6);
        run_phase(make_pattern(1), 5'd1, 1'b1, 1'b1, 1'b0, 0, 0);
        drain();

        $display("Sent %0d items under %0d register settings; checked %0d line results",
                 items_sent, settings_loaded, lines_done);
        $display("(%0d selected) and %0d end-of-file summaries, with idle, stall and hold-off",
                 lines_picked, files_done);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
